// File: rtl/sdcf_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the crc7 byte update for the sd spi command framer
// no dependencies
package sdcf_pkg;

    localparam int BYTE_W     = 8;
    localparam int ARG_W      = 32;
    localparam int CRC_W      = 7;
    localparam int BEAT_W     = 3;
    localparam int S_TDATA_W  = 48;

    localparam logic [CRC_W-1:0]  CRC7_POLY        = 7'h09;
    localparam logic [BYTE_W-1:0] IDLE_BYTE        = 8'hFF;
    localparam logic [BYTE_W-1:0] POLL_LIMIT_RESET = 8'd100;

    typedef enum logic [0:0]
    {
        ACT_ISSUE   = 1'b0,
        ACT_RX_BYTE = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        KIND_TX       = 2'd0,
        KIND_RESPONSE = 2'd1,
        KIND_TIMEOUT  = 2'd2
    } kind_t;

    typedef enum logic [BEAT_W-1:0]
    {
        BEAT_FLUSH = 3'd0,
        BEAT_CMD   = 3'd1,
        BEAT_ARG3  = 3'd2,
        BEAT_ARG2  = 3'd3,
        BEAT_ARG1  = 3'd4,
        BEAT_ARG0  = 3'd5,
        BEAT_CRC   = 3'd6,
        BEAT_POLL  = 3'd7
    } beat_t;

    // msb-first crc7 update with one byte, generator x^7 + x^3 + 1
    function automatic logic [CRC_W-1:0] crc7_feed(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = data[i] ^ c[CRC_W-1];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/sd_spi_command_framer_crc7_top.sv
`timescale 1ns / 1ps
// sd spi-mode command framer: crc7 framing, response polling and timeout
// depends on sdcf_pkg
//
// usage
//   s_* stream takes items: tuser selects issue (0) or received card byte (1)
//   an issue transfer yields eight transmit bytes on m_*: 0xff flush, command,
//   argument msb first, crc7 with end bit, 0xff poll; tlast marks the poll byte
//   a received byte while waiting gives a response, another poll or a timeout,
//   each as one transfer with tlast set; received bytes while idle are dropped
//   cfg_* writes poll_limit, the count of extra polls before a timeout
// timing
//   first result reaches m_* through the input register and then the output register
//   an issue occupies the framer until its poll byte is sent, one byte per cycle
//   into the output register while m_* is not stalled; received bytes are taken one
//   per cycle likewise, and the crc is accumulated one byte per cycle while the frame goes out
// reset and stall
//   reset clears the output valid and returns to idle with poll_limit 100
//   while m_tready is low the output holds and the next input waits in the
//   input register; s_tready drops once that register is full
module sd_spi_command_framer_crc7_top
    import sdcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // command_byte[7:0], argument[39:8], rx_byte[47:40]
    input  logic                 s_tuser,   // action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,   // data_byte[7:0]
    output logic [1:0]           m_tuser,   // kind[1:0]
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BYTE_W-1:0]    cfg_data   // poll_limit[7:0]
);

    // input register
    logic              work_valid_reg;
    action_t           action_reg;
    logic [BYTE_W-1:0] cmd_reg;
    logic [ARG_W-1:0]  arg_reg;
    logic [BYTE_W-1:0] rx_reg;
    beat_t             beat_reg, beat_next;

    // block state
    logic [BYTE_W-1:0] poll_limit_reg;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic              awaiting_reg, awaiting_next;
    logic [BYTE_W-1:0] polls_left_reg, polls_left_next;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0] m_tdata_reg, m_tdata_next;
    kind_t             m_kind_reg, m_kind_next;
    logic              m_tlast_reg, m_tlast_next;

    logic              out_free;
    logic              drop;
    logic              step;
    logic              final_beat;
    logic              in_xfer;
    logic [BYTE_W-1:0] frame_byte;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign drop       = (action_reg == ACT_RX_BYTE) && !awaiting_reg;
    assign step       = work_valid_reg && (out_free || drop);
    assign final_beat = step && ((action_reg == ACT_RX_BYTE) || (beat_reg == BEAT_POLL));
    assign s_tready   = !work_valid_reg || final_beat;
    assign in_xfer    = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb
    begin
        case (beat_reg)
            BEAT_FLUSH: frame_byte = IDLE_BYTE;
            BEAT_CMD:   frame_byte = cmd_reg;
            BEAT_ARG3:  frame_byte = arg_reg[31:24];
            BEAT_ARG2:  frame_byte = arg_reg[23:16];
            BEAT_ARG1:  frame_byte = arg_reg[15:8];
            BEAT_ARG0:  frame_byte = arg_reg[7:0];
            BEAT_CRC:   frame_byte = {crc_reg, 1'b1};
            BEAT_POLL:  frame_byte = IDLE_BYTE;
            default:    frame_byte = IDLE_BYTE;
        endcase
    end

    always_comb
    begin
        beat_next       = beat_reg;
        crc_next        = crc_reg;
        awaiting_next   = awaiting_reg;
        polls_left_next = polls_left_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_kind_next     = m_kind_reg;
        m_tlast_next    = m_tlast_reg;

        if (step && !drop)
        begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = 1'b1;
            if (action_reg == ACT_ISSUE)
            begin
                m_kind_next  = KIND_TX;
                m_tdata_next = frame_byte;
                m_tlast_next = (beat_reg == BEAT_POLL);
                beat_next    = beat_t'(beat_reg + 3'd1);
                if (beat_reg == BEAT_CMD)
                begin
                    crc_next = crc7_feed('0, frame_byte);
                end
                else if (beat_reg == BEAT_ARG3 || beat_reg == BEAT_ARG2 ||
                         beat_reg == BEAT_ARG1 || beat_reg == BEAT_ARG0)
                begin
                    crc_next = crc7_feed(crc_reg, frame_byte);
                end
                if (beat_reg == BEAT_POLL)
                begin
                    awaiting_next   = 1'b1;
                    polls_left_next = poll_limit_reg;
                end
            end
            else if (rx_reg != IDLE_BYTE)
            begin
                m_kind_next   = KIND_RESPONSE;
                m_tdata_next  = rx_reg;
                awaiting_next = 1'b0;
            end
            else if (polls_left_reg != '0)
            begin
                m_kind_next     = KIND_TX;
                m_tdata_next    = IDLE_BYTE;
                polls_left_next = polls_left_reg - 8'd1;
            end
            else
            begin
                m_kind_next   = KIND_TIMEOUT;
                m_tdata_next  = IDLE_BYTE;
                awaiting_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            beat_reg       <= BEAT_FLUSH;
            poll_limit_reg <= POLL_LIMIT_RESET;
            crc_reg        <= '0;
            awaiting_reg   <= 1'b0;
            polls_left_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                work_valid_reg <= 1'b1;
            end
            else if (final_beat)
            begin
                work_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                poll_limit_reg <= cfg_data;
            end
            beat_reg       <= beat_next;
            crc_reg        <= crc_next;
            awaiting_reg   <= awaiting_next;
            polls_left_reg <= polls_left_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            action_reg <= action_t'(s_tuser);
            cmd_reg    <= s_tdata[7:0];
            arg_reg    <= s_tdata[39:8];
            rx_reg     <= s_tdata[47:40];
        end
        m_tdata_reg <= m_tdata_next;
        m_kind_reg  <= m_kind_next;
        m_tlast_reg <= m_tlast_next;
    end

    // response and timeout are always the single, last result of their item
    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_kind_reg != KIND_TX) |-> m_tlast_reg)
        else $error("response or timeout without tlast");

    // leaving the wait state always comes with a response or timeout transfer
    a_wait_exit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(awaiting_reg) |->
            (m_tvalid_reg && (m_kind_reg == KIND_RESPONSE || m_kind_reg == KIND_TIMEOUT)))
        else $error("wait ended without response or timeout");

    // the frame counter only runs inside an issue item
    a_beat_in_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_reg != BEAT_FLUSH) |-> (work_valid_reg && action_reg == ACT_ISSUE))
        else $error("frame counter running outside an issue");

endmodule

// File: tb/sv/sd_spi_command_framer_crc7_checker.sv
`timescale 1ns / 1ps
// checker for the sd spi command framer: watches the config, input and output channels,
// predicts every frame byte, poll, response and timeout, and compares each output transfer
// depends on sdcf_pkg
module sd_spi_command_framer_crc7_checker
    import sdcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [BYTE_W-1:0]    m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [BYTE_W-1:0]    cfg_data,
    output int                   errors,
    output int                   outstanding
);

    typedef struct packed
    {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } card_xfer_t;

    card_xfer_t        expected_xfers[$];
    logic [BYTE_W-1:0] poll_limit_copy;
    logic              waiting_reply;
    logic [BYTE_W-1:0] polls_remaining;

    // crc7 over command byte and argument, bit serial, msb first
    function automatic logic [CRC_W-1:0] command_crc7(input logic [BYTE_W+ARG_W-1:0] body);
        logic [CRC_W-1:0] r;
        logic             top;
        r = '0;
        for (int i = BYTE_W + ARG_W - 1; i >= 0; i--)
        begin
            top = r[6] ^ body[i];
            r   = {r[5:3], r[2] ^ top, r[1:0], top};
        end
        return r;
    endfunction

    task automatic report(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic push_xfer(input kind_t k, input logic [BYTE_W-1:0] d, input logic l);
        card_xfer_t x;
        x.kind = k;
        x.data = d;
        x.last = l;
        expected_xfers.push_back(x);
    endtask

    task automatic frame_command(input logic [BYTE_W-1:0] cmd, input logic [ARG_W-1:0] arg);
        logic [CRC_W-1:0] crc;
        crc = command_crc7({cmd, arg});
        push_xfer(KIND_TX, IDLE_BYTE, 1'b0);
        push_xfer(KIND_TX, cmd, 1'b0);
        push_xfer(KIND_TX, arg[31:24], 1'b0);
        push_xfer(KIND_TX, arg[23:16], 1'b0);
        push_xfer(KIND_TX, arg[15:8], 1'b0);
        push_xfer(KIND_TX, arg[7:0], 1'b0);
        push_xfer(KIND_TX, {crc, 1'b1}, 1'b0);
        push_xfer(KIND_TX, IDLE_BYTE, 1'b1);
        waiting_reply   = 1'b1;
        polls_remaining = poll_limit_copy;
    endtask

    task automatic take_card_byte(input logic [BYTE_W-1:0] rx);
        if (waiting_reply)
        begin
            if (rx != IDLE_BYTE)
            begin
                push_xfer(KIND_RESPONSE, rx, 1'b1);
                waiting_reply = 1'b0;
            end
            else if (polls_remaining != 0)
            begin
                polls_remaining = polls_remaining - 8'd1;
                push_xfer(KIND_TX, IDLE_BYTE, 1'b1);
            end
            else
            begin
                push_xfer(KIND_TIMEOUT, IDLE_BYTE, 1'b1);
                waiting_reply = 1'b0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        card_xfer_t want;
        if (!rst_n)
        begin
            poll_limit_copy = POLL_LIMIT_RESET;
            waiting_reply   = 1'b0;
            polls_remaining = '0;
            expected_xfers.delete();
            errors          = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                poll_limit_copy = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                if (action_t'(s_tuser) == ACT_ISSUE)
                begin
                    frame_command(s_tdata[7:0], s_tdata[39:8]);
                end
                else
                begin
                    take_card_byte(s_tdata[47:40]);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_xfers.size() == 0)
                begin
                    report($sformatf("unexpected transfer kind %0d data %02h last %0b",
                                     m_tuser, m_tdata, m_tlast));
                end
                else
                begin
                    want = expected_xfers.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        report($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
                    end
                    if (m_tdata !== want.data)
                    begin
                        report($sformatf("data_byte %02h, expected %02h", m_tdata, want.data));
                    end
                    if (m_tlast !== want.last)
                    begin
                        report($sformatf("last %0b, expected %0b", m_tlast, want.last));
                    end
                end
            end
        end
        outstanding = expected_xfers.size();
    end

endmodule

// File: tb/sv/sd_spi_command_framer_crc7_top_test.sv
`timescale 1ns / 1ps
// test top for sd_spi_command_framer_crc7_top: drives commands, card bytes and poll limits
// with random gaps and stalls, and gives the verdict from the checker's error count
// depends on sdcf_pkg, sd_spi_command_framer_crc7_top and sd_spi_command_framer_crc7_checker
module sd_spi_command_framer_crc7_top_test
    import sdcf_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 14;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BYTE_W-1:0]    m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [BYTE_W-1:0]    cfg_data;

    int   errors;
    int   outstanding;
    int   cycle_count = 0;
    int   cur_limit;
    int   phase_items;
    logic s_burst = 1'b0;
    logic m_burst = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sd_spi_command_framer_crc7_top_test: errors");
            $finish;
        end
    end

    sd_spi_command_framer_crc7_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sd_spi_command_framer_crc7_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    task automatic send_item(input action_t act, input logic [BYTE_W-1:0] cmd,
                             input logic [ARG_W-1:0] arg, input logic [BYTE_W-1:0] rx);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {rx, arg, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic issue_cmd(input logic [BYTE_W-1:0] cmd, input logic [ARG_W-1:0] arg);
        send_item(ACT_ISSUE, cmd, arg, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic card_byte(input logic [BYTE_W-1:0] rx);
        send_item(ACT_RX_BYTE, BYTE_W'($urandom_range(0, 255)), $urandom, rx);
    endtask

    // close any pending wait, drain all results, then let the block go quiet
    task automatic settle;
        card_byte(8'h00);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= BYTE_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_limit = value;
    endtask

    // an occasional stray card byte, a command, a run of idle bytes, then mostly a response
    task automatic run_exchange;
        int polls;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            card_byte(BYTE_W'($urandom_range(0, 255)));
        end
        issue_cmd(BYTE_W'($urandom_range(0, 255)), $urandom);
        polls = $urandom_range(0, cur_limit + 1);
        repeat (polls) card_byte(IDLE_BYTE);
        phase_items += 1 + polls;
        if (polls <= cur_limit)
        begin
            pick = $urandom_range(0, 7);
            if (pick < 6)
            begin
                card_byte(BYTE_W'($urandom_range(0, 254)));
                phase_items++;
            end
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            int stall;
            stall = m_burst ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        int limits[5];
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        cur_limit = POLL_LIMIT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset poll limit: card bytes dropped while idle, polls, responses, abandoned wait
        card_byte(IDLE_BYTE);
        card_byte(8'h00);
        issue_cmd(8'h40, 32'h0000_0000);
        card_byte(IDLE_BYTE);
        card_byte(IDLE_BYTE);
        card_byte(8'h01);
        issue_cmd(8'h48, 32'h0000_01AA);
        card_byte(8'h00);
        issue_cmd(8'hFF, 32'hFFFF_FFFF);
        issue_cmd(8'h00, 32'h0000_0000);
        card_byte(8'hFE);
        issue_cmd(8'h7A, 32'h8000_0001);
        card_byte(8'h80);
        settle();

        // zero poll limit: first idle byte times out
        write_limit(0);
        issue_cmd(8'h41, 32'h0000_0000);
        card_byte(IDLE_BYTE);
        card_byte(IDLE_BYTE);
        issue_cmd(8'h77, 32'h5A5A_A5A5);
        card_byte(8'h7F);
        settle();

        limits[0] = 1;
        limits[1] = 0;
        limits[2] = 3;
        limits[3] = 2;
        limits[4] = $urandom_range(0, 6);
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            s_burst = ($urandom_range(0, 3) == 0);
            m_burst = ($urandom_range(0, 3) == 0);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) run_exchange();
            settle();
        end

        // widest poll limit, three polls then a response
        s_burst = 1'b0;
        m_burst = 1'b0;
        write_limit(255);
        issue_cmd(8'h51, 32'h1234_5678);
        repeat (3) card_byte(IDLE_BYTE);
        card_byte(8'h05);
        settle();

        if (errors == 0)
        begin
            $display("sd_spi_command_framer_crc7_top_test: clean");
        end
        else
        begin
            $display("sd_spi_command_framer_crc7_top_test: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/sdcf_pkg.sv
rtl/sd_spi_command_framer_crc7_top.sv
tb/sv/sd_spi_command_framer_crc7_checker.sv
tb/sv/sd_spi_command_framer_crc7_top_test.sv
